[sv/rrps_pkg.sv]
// Shared types and constants for the round-robin process scheduler.
`timescale 1ns / 1ps
`default_nettype none

package rrps_pkg;

  localparam int MAX_PROCS_DEF = 16;
  localparam logic [15:0] QUANTUM_RESET = 16'd10;

  localparam logic MODE_CREATE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  localparam logic [1:0] STAT_RUNNING = 2'd0;
  localparam logic [1:0] STAT_DONE    = 2'd1;
  localparam logic [1:0] STAT_CREATED = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RING,
    ST_SLOT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic cap;
    logic exec;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        switch_now;
    logic [3:0]  running_id;
    logic [15:0] running_base;
    logic [15:0] running_size;
  } result_t;

endpackage

`default_nettype wire

[sv/rrps_ctrl.sv]
// Controller state machine that sequences each word through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module rrps_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire              out_tready,
  output rrps_pkg::cmd_t   cmd
);
  import rrps_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r & ~out_tready;
    in_tready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_RING;
      end
      ST_RING: begin
        state_nxt = ST_SLOT;
      end
      ST_SLOT: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

[sv/rrps_dp.sv]
// Datapath with the process table, the ready ring, the tick counter and the result register.
`timescale 1ns / 1ps
`default_nettype none

module rrps_dp #(
  parameter int MAX_PROCS = rrps_pkg::MAX_PROCS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  rrps_pkg::cmd_t     cmd,
  input  wire                cfg_wr_en,
  input  wire  [15:0]        cfg_wr_data,
  input  wire                in_mode,
  input  wire  [15:0]        in_base,
  input  wire  [15:0]        in_size,
  input  wire                in_term,
  output rrps_pkg::result_t  res
);
  import rrps_pkg::*;

  localparam int IDW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW  = $clog2(MAX_PROCS + 1);
  localparam int SW  = IDW + 1;

  logic [15:0]    quantum_r;
  logic [IDW-1:0] head_r, head_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  next_id_r, next_id_nxt;
  logic [15:0]    ticks_r, ticks_nxt;

  logic           mode_r, term_r;
  logic [15:0]    base_r, size_r;
  logic [1:0]     stat_r, stat_nxt;
  logic           sw_r, sw_nxt;

  logic [15:0]    base_mem [MAX_PROCS];
  logic [15:0]    size_mem [MAX_PROCS];
  logic [IDW-1:0] ring_mem [MAX_PROCS];
  logic [IDW-1:0] ring_rd_r;
  logic [15:0]    base_rd_r, size_rd_r;

  logic [SW-1:0]  tail_sum, tail_pos;
  logic [IDW-1:0] tail_idx, head_inc;
  logic           slot_we, ring_we;
  logic [IDW-1:0] ring_wdata;

  result_t        res_r;

  assign tail_sum = SW'(head_r) + SW'(count_r);
  assign tail_pos = (tail_sum >= SW'(MAX_PROCS)) ? tail_sum - SW'(MAX_PROCS) : tail_sum;
  assign tail_idx = tail_pos[IDW-1:0];
  assign head_inc = (head_r == IDW'(MAX_PROCS - 1)) ? '0 : head_r + IDW'(1);

  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    next_id_nxt = next_id_r;
    ticks_nxt   = ticks_r;
    stat_nxt    = STAT_RUNNING;
    sw_nxt      = 1'b0;
    slot_we     = 1'b0;
    ring_we     = 1'b0;
    ring_wdata  = next_id_r[IDW-1:0];
    if (mode_r == MODE_CREATE) begin
      if (next_id_r >= CW'(MAX_PROCS)) begin
        stat_nxt = STAT_FULL;
      end else begin
        slot_we     = 1'b1;
        ring_we     = 1'b1;
        next_id_nxt = next_id_r + CW'(1);
        count_nxt   = count_r + CW'(1);
        stat_nxt    = STAT_CREATED;
        sw_nxt      = (count_r == '0);
      end
    end else if (count_r == '0) begin
      stat_nxt = STAT_DONE;
    end else if (term_r) begin
      head_nxt  = head_inc;
      count_nxt = count_r - CW'(1);
      if (count_r == CW'(1)) begin
        stat_nxt = STAT_DONE;
      end else begin
        ticks_nxt = '0;
        sw_nxt    = 1'b1;
      end
    end else if (ticks_r == quantum_r) begin
      ticks_nxt = '0;
      if (count_r != CW'(1)) begin
        ring_we    = 1'b1;
        ring_wdata = ring_rd_r;
        head_nxt   = head_inc;
        sw_nxt     = 1'b1;
      end
    end else begin
      ticks_nxt = ticks_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RESET;
      head_r    <= '0;
      count_r   <= '0;
      next_id_r <= '0;
      ticks_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        quantum_r <= cfg_wr_data;
      end
      if (cmd.exec) begin
        head_r    <= head_nxt;
        count_r   <= count_nxt;
        next_id_r <= next_id_nxt;
        ticks_r   <= ticks_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_r <= in_mode;
      base_r <= in_base;
      size_r <= in_size;
      term_r <= in_term;
    end
    if (cmd.exec) begin
      stat_r <= stat_nxt;
      sw_r   <= sw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && ring_we) begin
      ring_mem[tail_idx] <= ring_wdata;
    end
    ring_rd_r <= ring_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && slot_we) begin
      base_mem[next_id_r[IDW-1:0]] <= base_r;
      size_mem[next_id_r[IDW-1:0]] <= size_r;
    end
    base_rd_r <= base_mem[ring_rd_r];
    size_rd_r <= size_mem[ring_rd_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_r.status     <= stat_r;
      res_r.switch_now <= sw_r;
      if (count_r == '0) begin
        res_r.running_id   <= '0;
        res_r.running_base <= '0;
        res_r.running_size <= '0;
      end else begin
        res_r.running_id   <= 4'(ring_rd_r);
        res_r.running_base <= base_rd_r;
        res_r.running_size <= size_rd_r;
      end
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

[sv/round_robin_process_scheduler_core.sv]
// Top level of the round-robin process scheduler.
//
// The input channel carries one create or tick word. in_tuser selects the
// kind (0 create, 1 tick); in_tdata holds the process base and size for a
// create and the finished flag for a tick. Every accepted word gives exactly
// one result word on the output channel: the status in out_tuser and the
// switch flag plus the id, base and size of the process at the queue head in
// out_tdata. The quantum is written through cfg_wr_en and cfg_wr_data; the
// user must write it only while the block is idle, which the block does not enforce.
// After acceptance an item passes the EXEC, RING, SLOT and OUT states, and its
// result is loaded in OUT; no new item is taken until it leaves OUT. RING and
// SLOT cover the chain of the ring read at the new head and the table read at
// the id it returns, both through registered memory ports.
// After reset the queue and table are empty and the quantum is 10; there is
// no clearing pass, so the first item can be taken right away.
// A result waits in the output register while the receiver stalls; the next
// item is still accepted and worked on, and its result is held back until
// the waiting one has been taken.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_process_scheduler_core #(
  parameter int MAX_PROCS = rrps_pkg::MAX_PROCS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,   // proc_base, proc_size, terminated, zero pad
  input  wire         in_tuser,   // mode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // switch_now, running_id, running_base, running_size, zero pad
  output logic [1:0]  out_tuser,  // status
  input  wire         cfg_wr_en,
  input  wire  [15:0] cfg_wr_data
);
  import rrps_pkg::*;

  cmd_t    cmd;
  result_t res;

  rrps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  rrps_dp #(
    .MAX_PROCS (MAX_PROCS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_mode     (in_tuser),
    .in_base     (in_tdata[15:0]),
    .in_size     (in_tdata[31:16]),
    .in_term     (in_tdata[32]),
    .res         (res)
  );

  assign out_tuser = res.status;
  assign out_tdata = {3'b000, res.running_size, res.running_base, res.running_id,
                      res.switch_now};

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("A second word was accepted while one is in flight.");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !out_tvalid) |-> ##5 out_tvalid)
    else $error("Result did not appear five cycles after acceptance.");

  a_switch_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == STAT_FULL || out_tuser == STAT_DONE)) |-> !out_tdata[0])
    else $error("Switch flag set on a done or table full result.");
`endif

endmodule

`default_nettype wire
